// File: rtl/core/homogeneous_triangle_clipper_macros.svh
// Assertion macros shared by the clipper checker.
`ifndef HOMOGENEOUS_TRIANGLE_CLIPPER_MACROS_SVH
`define HOMOGENEOUS_TRIANGLE_CLIPPER_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define HTC_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |-> (rhs)) \
        else $error("clipper check failed");

// Condition that must hold in the cycle after the trigger.
`define HTC_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |=> (rhs)) \
        else $error("clipper check failed");

`endif

// File: rtl/core/htc_pkg.sv
// Types and constants shared by the triangle clipper modules.
`default_nettype none
package htc_pkg;
    localparam int MAX_VERTICES = 9;
    localparam int FRAC_BITS    = 16;
    localparam int NCOMP        = 8;
    localparam int COMP_W       = 32;
    localparam int CELLS        = 2 * MAX_VERTICES;
    localparam int IDX_W        = $clog2(CELLS);
    localparam int CNT_W        = $clog2(CELLS + 1);
    localparam int MCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int DIST_W       = COMP_W + 2;
    localparam int DEN_W        = COMP_W + 3;
    localparam int T_W          = FRAC_BITS + 1;
    localparam int PROD_W       = COMP_W + 1 + T_W + 1;
    localparam int NUM_PASS     = 6;
    localparam int PASS_W       = 3;
    localparam int K_W          = $clog2(NCOMP);
    localparam int LOAD_MAX     = 2;

    typedef logic [NCOMP-1:0][COMP_W-1:0] vtx_t;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [T_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_POP   = 9'b000000010,
        S_DIST  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_ADD   = 9'b000100000,
        S_PUSHX = 9'b001000000,
        S_PUSHC = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;
endpackage
`default_nettype wire

// File: rtl/core/htc_cell.sv
// One vertex cell of the polygon queue; shifts toward the head or loads a new vertex.
`default_nettype none
module htc_cell
    import htc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic shift_en,
    input  wire vtx_t nb_data,
    input  wire logic wr_en,
    input  wire vtx_t wr_data,
    output vtx_t      data
);
    vtx_t data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            data_reg <= wr_data;
        end else if (shift_en) begin
            data_reg <= nb_data;
        end
    end

    assign data = data_reg;
endmodule
`default_nettype wire

// File: rtl/core/htc_divider.sv
// Restoring divider giving the crossing fraction one quotient bit per cycle.
`default_nettype none
module htc_divider
    import htc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    localparam int R_W   = DEN_W + 1;
    localparam int CN_W  = $clog2(T_W + 1);

    logic [R_W-1:0]   r_reg, r_next;
    logic [DEN_W-1:0] den_reg;
    logic [T_W-1:0]   q_reg;
    logic [CN_W-1:0]  cnt_reg;
    logic             busy_reg, done_reg;
    logic             ge;
    logic [R_W-1:0]   rem;

    always_comb begin
        ge     = r_reg >= {1'b0, den_reg};
        rem    = ge ? (r_reg - {1'b0, den_reg}) : r_reg;
        r_next = {rem[R_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CN_W'(T_W);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CN_W'(1);
            done_reg <= cnt_reg == CN_W'(1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            r_reg   <= {1'b0, req.num};
            den_reg <= req.den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            r_reg <= r_next;
            q_reg <= {q_reg[T_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;
endmodule
`default_nettype wire

// File: rtl/core/homogeneous_triangle_clipper.sv
// Homogeneous triangle clipper against the six clip-space planes, x, -x, y, -y, z, -z.
// A vertex without tlast is queued, up to two per triangle, and any further one is taken
// and dropped. The vertex with tlast starts clipping; s_tready stays low until every
// result of that triangle has been taken. Each plane pass walks the polygon queue,
// popping each vertex and testing its distance to the plane, and queues the vertices
// kept. A plane crossing waits on the divider (one quotient bit per cycle), then forms
// each component with a multiply and an add on the shared multiplier, and queues the
// new vertex. Results then leave at one per cycle while m_tready is high. A wholly
// rejected triangle gives one result with tuser set and zero data.
`default_nettype none
module homogeneous_triangle_clipper
    import htc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, pos_w, attr_a, attr_b, attr_c, attr_d (32 bits each)
    input  wire logic [255:0] s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x, out_y, out_z, out_w, out_attr_a, out_attr_b, out_attr_c, out_attr_d
    output logic [255:0]      m_tdata,
    output logic              m_tlast,
    // rejected
    output logic              m_tuser
);
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         q_cnt_reg, q_cnt_next;
    logic [MCNT_W-1:0]        n_rem_reg, n_rem_next;
    logic [MCNT_W-1:0]        m_reg, m_next;
    logic [PASS_W-1:0]        pass_reg, pass_next;
    logic                     first_reg, first_next;
    logic [1:0]               loaded_reg, loaded_next;
    logic [K_W-1:0]           k_reg, k_next;

    vtx_t                     cur_reg, prev_reg, last_reg, new_reg;
    logic [T_W-1:0]           t_reg;
    logic signed [PROD_W-1:0] prod_reg;

    vtx_t                     cell_q [CELLS];
    vtx_t                     push_data;
    logic                     shift_en, push_en;
    logic                     s_acc, m_acc;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic [K_W-1:0]           axis;
    logic signed [DIST_W-1:0] d_cur, d_prev;
    logic signed [DEN_W-1:0]  d_diff;
    logic                     in_cur, in_prev, room;

    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++) begin : g_cell
            vtx_t nb;
            if (gi == CELLS - 1) begin : g_end
                assign nb = '0;
            end else begin : g_mid
                assign nb = cell_q[gi+1];
            end
            htc_cell u_cell (
                .aclk    (aclk),
                .shift_en(shift_en),
                .nb_data (nb),
                .wr_en   (push_en && (q_cnt_reg[IDX_W-1:0] == IDX_W'(gi))),
                .wr_data (push_data),
                .data    (cell_q[gi])
            );
        end
    endgenerate

    htc_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // Plane distance: w - c for the positive side, w + c for the negative side.
    always_comb begin
        axis   = {1'b0, pass_reg[2:1]};
        d_cur  = pass_reg[0]
               ? DIST_W'($signed(cur_reg[3])) + DIST_W'($signed(cur_reg[axis]))
               : DIST_W'($signed(cur_reg[3])) - DIST_W'($signed(cur_reg[axis]));
        d_prev = pass_reg[0]
               ? DIST_W'($signed(prev_reg[3])) + DIST_W'($signed(prev_reg[axis]))
               : DIST_W'($signed(prev_reg[3])) - DIST_W'($signed(prev_reg[axis]));
        d_diff = DEN_W'(d_cur) - DEN_W'(d_prev);
        in_cur  = !d_cur[DIST_W-1];
        in_prev = !d_prev[DIST_W-1];
        room    = m_reg < MCNT_W'(MAX_VERTICES);
        div_req.num = d_cur[DIST_W-1] ? DEN_W'(-DEN_W'(d_cur)) : DEN_W'(d_cur);
        div_req.den = d_diff[DEN_W-1] ? -d_diff : d_diff;
        div_req.start = (state_reg == S_DIST) && (in_cur != in_prev) && room;
    end

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb begin
        state_next  = state_reg;
        q_cnt_next  = q_cnt_reg;
        n_rem_next  = n_rem_reg;
        m_next      = m_reg;
        pass_next   = pass_reg;
        first_next  = first_reg;
        loaded_next = loaded_reg;
        k_next      = k_reg;
        shift_en    = 1'b0;
        push_en     = 1'b0;
        push_data   = cur_reg;
        s_tready    = state_reg == S_LOAD;
        m_tvalid    = state_reg == S_OUT;
        case (state_reg)
            S_LOAD: begin
                push_data = vtx_t'(s_tdata);
                if (s_acc) begin
                    if (s_tlast) begin
                        push_en     = 1'b1;
                        q_cnt_next  = q_cnt_reg + 1'b1;
                        n_rem_next  = MCNT_W'(loaded_reg) + 1'b1;
                        m_next      = '0;
                        pass_next   = '0;
                        first_next  = 1'b1;
                        loaded_next = '0;
                        state_next  = S_POP;
                    end else if (loaded_reg < 2'(LOAD_MAX)) begin
                        push_en     = 1'b1;
                        q_cnt_next  = q_cnt_reg + 1'b1;
                        loaded_next = loaded_reg + 1'b1;
                    end
                end
            end
            S_POP: begin
                if (n_rem_reg == '0) begin
                    if (m_reg == '0 || pass_reg == PASS_W'(NUM_PASS - 1)) begin
                        state_next = S_OUT;
                    end else begin
                        pass_next  = pass_reg + 1'b1;
                        n_rem_next = m_reg;
                        m_next     = '0;
                        first_next = 1'b1;
                    end
                end else begin
                    shift_en   = 1'b1;
                    q_cnt_next = q_cnt_reg - 1'b1;
                    n_rem_next = n_rem_reg - 1'b1;
                    first_next = 1'b0;
                    state_next = S_DIST;
                end
            end
            S_DIST: begin
                if ((in_cur != in_prev) && room) begin
                    state_next = S_DIV;
                end else if (in_cur && room) begin
                    state_next = S_PUSHC;
                end else begin
                    state_next = S_POP;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    k_next     = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_ADD;
            end
            S_ADD: begin
                if (k_reg == K_W'(NCOMP - 1)) begin
                    state_next = S_PUSHX;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_PUSHX: begin
                push_en    = 1'b1;
                push_data  = new_reg;
                q_cnt_next = q_cnt_reg + 1'b1;
                m_next     = m_reg + 1'b1;
                if (in_cur && (m_reg + 1'b1) < MCNT_W'(MAX_VERTICES)) begin
                    state_next = S_PUSHC;
                end else begin
                    state_next = S_POP;
                end
            end
            S_PUSHC: begin
                push_en    = 1'b1;
                q_cnt_next = q_cnt_reg + 1'b1;
                m_next     = m_reg + 1'b1;
                state_next = S_POP;
            end
            S_OUT: begin
                if (m_acc) begin
                    if (q_cnt_reg == '0) begin
                        state_next = S_LOAD;
                    end else begin
                        shift_en   = 1'b1;
                        q_cnt_next = q_cnt_reg - 1'b1;
                        if (q_cnt_reg == CNT_W'(1)) begin
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            q_cnt_reg  <= '0;
            n_rem_reg  <= '0;
            m_reg      <= '0;
            pass_reg   <= '0;
            first_reg  <= 1'b0;
            loaded_reg <= '0;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            q_cnt_reg  <= q_cnt_next;
            n_rem_reg  <= n_rem_next;
            m_reg      <= m_next;
            pass_reg   <= pass_next;
            first_reg  <= first_next;
            loaded_reg <= loaded_next;
            k_reg      <= k_next;
        end
    end

    // The first vertex of a pass pairs with the last one queued, which closes the polygon.
    always_ff @(posedge aclk) begin
        if (state_reg == S_POP && n_rem_reg != '0) begin
            cur_reg  <= cell_q[0];
            prev_reg <= first_reg ? last_reg : cur_reg;
        end
        if (push_en) begin
            last_reg <= push_data;
        end
        if (state_reg == S_DIV && div_rsp.done) begin
            t_reg <= div_rsp.quo;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= (PROD_W'($signed(prev_reg[k_reg])) - PROD_W'($signed(cur_reg[k_reg])))
                      * PROD_W'($signed({1'b0, t_reg}));
        end
        // Taking bits from FRAC_BITS up of the signed product floors the scaled step.
        if (state_reg == S_ADD) begin
            new_reg[k_reg] <= cur_reg[k_reg] + prod_reg[FRAC_BITS +: COMP_W];
        end
    end

    assign m_tuser = q_cnt_reg == '0;
    assign m_tlast = (q_cnt_reg == '0) || (q_cnt_reg == CNT_W'(1));
    assign m_tdata = (q_cnt_reg == '0) ? '0 : 256'(cell_q[0]);
endmodule
`default_nettype wire

// File: rtl/core/htc_checker.sv
// Port-level checks for the triangle clipper, bound to the top level.
`default_nettype none
`include "homogeneous_triangle_clipper_macros.svh"
module htc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [255:0] s_tdata,
    input wire logic         s_tlast,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [255:0] m_tdata,
    input wire logic         m_tlast,
    input wire logic         m_tuser
);
    `HTC_ASSERT_IMP(a_rej_last, m_tvalid && m_tuser, m_tlast)
    `HTC_ASSERT_IMP(a_rej_zero, m_tvalid && m_tuser, m_tdata == 256'd0)
    `HTC_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
    `HTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
endmodule

bind homogeneous_triangle_clipper htc_checker u_htc_checker (.*);
`default_nettype wire

// File: test/htc_checker.sv
// Checker for the triangle clipper: mirrors the clipping and compares every result item.
`timescale 1ns / 100ps
`default_nettype none
module htc_scoreboard
    import htc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [255:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [255:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         m_tuser,
    output int                fail_count,
    output int                pending_count,
    output int                vertex_count_seen,
    output int                reject_count
);
    typedef struct packed {
        logic [255:0] data;
        logic         eop;
        logic         rej;
    } clip_vtx_t;

    typedef logic signed [63:0] wide_t;

    clip_vtx_t   expected_q[$];
    logic [255:0] held[3];
    int          held_n;
    string       comp_name[NCOMP] = '{"out_x", "out_y", "out_z", "out_w",
                                      "out_attr_a", "out_attr_b", "out_attr_c", "out_attr_d"};

    function automatic wide_t comp_of(logic [255:0] v, int k);
        return wide_t'($signed(v[k*32 +: 32]));
    endfunction

    function automatic wide_t dist_of(logic [255:0] v, int axis, bit neg);
        return neg ? comp_of(v, 3) + comp_of(v, axis) : comp_of(v, 3) - comp_of(v, axis);
    endfunction

    // One Sutherland-Hodgman pass; the walk begins at the closing edge.
    function automatic void clip_plane(ref logic [255:0] poly[$], input int axis, input bit neg);
        logic [255:0] res[$];
        logic [255:0] nv;
        logic [255:0] pv, cv;
        wide_t dp, dc, den, t, a, prod, q;
        int n;
        n = poly.size();
        if (n == 0) return;
        pv = poly[n-1];
        dp = dist_of(pv, axis, neg);
        for (int i = 0; i < n; i++) begin
            cv = poly[i];
            dc = dist_of(cv, axis, neg);
            if ((dc >= 0) != (dp >= 0) && res.size() < MAX_VERTICES) begin
                den = dc - dp;
                if (den < 0) den = -den;
                t = 0;
                if (den != 0) t = ((dc < 0 ? -dc : dc) <<< FRAC_BITS) / den;
                for (int k = 0; k < NCOMP; k++) begin
                    a = comp_of(cv, k);
                    prod = (comp_of(pv, k) - a) * t;
                    q = prod >>> FRAC_BITS;  // arithmetic shift floors
                    nv[k*32 +: 32] = 32'(a + q);
                end
                res = {res, nv};
            end
            if (dc >= 0 && res.size() < MAX_VERTICES) res = {res, cv};
            pv = cv;
            dp = dc;
        end
        poly = res;
    endfunction

    function automatic void predict_triangle(logic [255:0] last_v);
        logic [255:0] poly[$];
        clip_vtx_t e;
        for (int i = 0; i < held_n; i++) poly = {poly, held[i]};
        poly = {poly, last_v};
        for (int p = 0; p < NUM_PASS; p++) clip_plane(poly, p >> 1, p[0]);
        if (poly.size() == 0) begin
            e = '{data: '0, eop: 1'b1, rej: 1'b1};
            expected_q = {expected_q, e};
        end else begin
            foreach (poly[i]) begin
                e = '{data: poly[i], eop: i == poly.size() - 1, rej: 1'b0};
                expected_q = {expected_q, e};
            end
        end
    endfunction

    always_ff @(posedge aclk) begin
        clip_vtx_t e;
        if (!aresetn) begin
            held_n <= 0;
            fail_count <= 0;
            pending_count <= 0;
            vertex_count_seen <= 0;
            reject_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tlast) begin
                    predict_triangle(s_tdata);
                    held_n <= 0;
                end else if (held_n < LOAD_MAX) begin
                    held[held_n] <= s_tdata;
                    held_n <= held_n + 1;
                end
            end
            if (m_tvalid && m_tready) begin
                vertex_count_seen <= vertex_count_seen + 1;
                if (m_tuser) reject_count <= reject_count + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result item");
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    for (int k = 0; k < NCOMP; k++)
                        if (m_tdata[k*32 +: 32] !== e.data[k*32 +: 32]) begin
                            $error("%s: expected %h actual %h", comp_name[k],
                                   e.data[k*32 +: 32], m_tdata[k*32 +: 32]);
                            fail_count <= fail_count + 1;
                        end
                    if (m_tlast !== e.eop) begin
                        $error("end_of_polygon: expected %b actual %b", e.eop, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                    if (m_tuser !== e.rej) begin
                        $error("rejected: expected %b actual %b", e.rej, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_q.size();
        end
    end
endmodule
`default_nettype wire

// File: test/tb_top.sv
// Top of the triangle clipper testbench: stimulus, idling and the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import htc_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    int           fail_count, pending_count, vertex_count_seen, reject_count;
    int           send_idle_pct, recv_idle_pct;
    int           vertex_items;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    homogeneous_triangle_clipper dut (.*);

    htc_scoreboard scoreboard_i (.*);

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // tvalid stays high between back-to-back items and drops only while idling.
    task automatic send_vertex(logic [255:0] v, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        vertex_items++;
    endtask

    function automatic logic [255:0] make_vertex(int x, int y, int z, int w);
        logic [255:0] v;
        v = {$urandom, $urandom, $urandom, $urandom, w, z, y, x};
        return v;
    endfunction

    // Coordinates near the clip volume so that most triangles cross some planes.
    function automatic logic [255:0] random_vertex();
        int w, sc;
        case ($urandom_range(9))
            0: return {$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
            1: sc = 32'h7fff_0000;
            default: sc = 32'h0004_0000;
        endcase
        w = $urandom_range(sc);
        if ($urandom_range(9) == 0) w = -w;
        return make_vertex(int'($urandom_range(2*sc)) - sc, int'($urandom_range(2*sc)) - sc,
                           int'($urandom_range(2*sc)) - sc, w);
    endfunction

    task automatic send_triangle(logic [255:0] a, logic [255:0] b, logic [255:0] c);
        send_vertex(a, 1'b0);
        send_vertex(b, 1'b0);
        send_vertex(c, 1'b1);
    endtask

    localparam int ONE = 32'h0001_0000;
    localparam int MAXI = 32'h7fff_ffff;
    localparam int MINI = 32'h8000_0000;

    initial begin
        send_idle_pct = 8;
        recv_idle_pct = 70;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Fully inside, fully rejected, straddling every plane.
        send_triangle(make_vertex(0, 0, 0, ONE), make_vertex(ONE/2, 0, 0, ONE),
                      make_vertex(0, ONE/2, 0, ONE));
        send_triangle(make_vertex(3*ONE, 0, 0, ONE), make_vertex(4*ONE, ONE, 0, ONE),
                      make_vertex(5*ONE, 0, ONE, ONE));
        send_triangle(make_vertex(-3*ONE, -3*ONE, -3*ONE, ONE),
                      make_vertex(3*ONE, 0, 3*ONE, ONE), make_vertex(0, 3*ONE, 0, ONE));
        // Extremes of the fields, all bits of every word.
        send_triangle({8{MAXI}}, {8{MINI}}, {8{32'hffff_ffff}});
        send_triangle({8{32'h0}}, make_vertex(MINI, MAXI, MINI, MAXI),
                      make_vertex(MAXI, MINI, MAXI, MAXI));
        // Short triangles: one and two vertices, then extra vertices ignored.
        send_vertex(make_vertex(0, 0, 0, ONE), 1'b1);
        send_vertex(make_vertex(-2*ONE, 0, 0, ONE), 1'b0);
        send_vertex(make_vertex(2*ONE, 0, 0, ONE), 1'b1);
        send_vertex(make_vertex(0, 0, 0, ONE), 1'b0);
        send_vertex(make_vertex(ONE, 0, 0, ONE), 1'b0);
        send_vertex(make_vertex(9*ONE, 0, 0, ONE), 1'b0);
        send_vertex(make_vertex(0, ONE, 0, ONE), 1'b1);
        // Degenerate triangle with w of zero at every vertex.
        send_triangle(make_vertex(0, 0, 0, 0), make_vertex(ONE, 0, 0, 0),
                      make_vertex(0, ONE, 0, 0));
        for (int i = 0; i < 35; i++) begin
            if (i == 12) begin send_idle_pct = 70; recv_idle_pct = 8; end
            if (i == 24) begin send_idle_pct = 0; recv_idle_pct = 0; end
            case ($urandom_range(9))
                0: send_vertex(random_vertex(), 1'b1);
                1: begin send_vertex(random_vertex(), 1'b0);
                   send_vertex(random_vertex(), 1'b1); end
                2: begin send_vertex(random_vertex(), 1'b0);
                   send_triangle(random_vertex(), random_vertex(), random_vertex()); end
                default: send_triangle(random_vertex(), random_vertex(), random_vertex());
            endcase
        end
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        $display("Sent %0d vertex items; checked %0d result items, %0d rejected triangles.",
                 vertex_items, vertex_count_seen, reject_count);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/htc_pkg.sv
rtl/core/htc_cell.sv
rtl/core/htc_divider.sv
rtl/core/homogeneous_triangle_clipper.sv
rtl/core/htc_checker.sv
test/htc_checker.sv
test/tb_top.sv
